>>> sv/tcw_pkg.sv
// Shared constants and types for the text console writer.
// Used by the channel interfaces, the front end, the command queue and the back end.
package tcw_pkg;

  // Field widths of the channels
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned INDEX_W   = 11;
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned CURCOL_W  = 7;
  localparam int unsigned CURROW_W  = 5;
  localparam int unsigned COLOR_W   = 8;

  // Widest cursor position over the supported grid sizes
  localparam int unsigned COL_MAX_W = 8;
  localparam int unsigned ROW_MAX_W = 7;

  localparam int unsigned CMD_FIFO_DEPTH = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Stream bytes with a meaning of their own
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0F;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  // One classified word from the front end to the back end
  typedef struct packed {
    cmd_kind_t            kind;
    logic [CELL_W-1:0]    wr_cell;
    logic [COL_MAX_W-1:0] wr_col;
    logic [ROW_MAX_W-1:0] wr_row;
    logic                 scroll;
    logic [COLOR_W-1:0]   blank_color;
    logic [INDEX_W-1:0]   read_index;
    logic [CURCOL_W-1:0]  rep_col;
    logic [CURROW_W-1:0]  rep_row;
    logic [COLOR_W-1:0]   rep_color;
  } cmd_t;

endpackage

>>> sv/tcw_ifs.sv
// Valid/ready channel interfaces of the text console writer.
// Depends on tcw_pkg for field widths.
interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::OP_W-1:0]     operation;
  logic [tcw_pkg::CHAR_W-1:0]   char_byte;
  logic [tcw_pkg::INDEX_W-1:0]  read_index;

  modport source (output valid, output operation, output char_byte, output read_index,
                  input ready);
  modport sink (input valid, input operation, input char_byte, input read_index,
                output ready);
endinterface

interface tcw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::CELL_W-1:0]    cell_data;
  logic [tcw_pkg::CURCOL_W-1:0]  cursor_column;
  logic [tcw_pkg::CURROW_W-1:0]  cursor_row;
  logic [tcw_pkg::COLOR_W-1:0]   text_color;
  logic                          scrolled;

  modport source (output valid, output cell_data, output cursor_column, output cursor_row,
                  output text_color, output scrolled, input ready);
  modport sink (input valid, input cell_data, input cursor_column, input cursor_row,
                input text_color, input scrolled, output ready);
endinterface

>>> sv/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/tcw_front.sv
// Front end: takes input words, keeps cursor, colour and escape state, and
// turns each word into one back-end command. Depends on tcw_pkg and tcw_ifs.
module tcw_front #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  tcw_in_if.sink        in_ch,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output tcw_pkg::cmd_t cmd_data
);

  localparam int unsigned CW = $clog2(COLUMNS);
  localparam int unsigned RW = $clog2(ROWS);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [CW:0]   COL_END  = (CW + 1)'(COLUMNS);
  localparam logic [RW:0]   ROW_END  = (RW + 1)'(ROWS);
  localparam logic [RW:0]   ROW_LAST = (RW + 1)'(ROWS - 1);

  logic [CW-1:0]                  col_r, col_nxt;
  logic [RW-1:0]                  row_r, row_nxt;
  logic [tcw_pkg::COLOR_W-1:0]    color_r, color_nxt;
  logic                           esc_r, esc_nxt;
  logic [CW:0]                    col_inc;
  logic [RW:0]                    row_wide;
  logic                           wr_en;
  logic [CW-1:0]                  wr_col;
  logic [RW-1:0]                  wr_row;
  logic [tcw_pkg::CHAR_W-1:0]     wr_char;
  logic                           scroll;
  logic                           accept;

  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid;
  assign accept      = in_ch.valid && cmd_ready;

  always_comb begin
    col_nxt   = col_r;
    row_wide  = {1'b0, row_r};
    color_nxt = color_r;
    esc_nxt   = esc_r;
    col_inc   = {1'b0, col_r} + 1'b1;
    wr_en     = 1'b0;
    wr_col    = col_r;
    wr_row    = row_r;
    wr_char   = in_ch.char_byte;
    scroll    = 1'b0;
    cmd_data  = '0;
    cmd_data.kind        = tcw_pkg::CMD_NONE;
    cmd_data.blank_color = color_r;
    cmd_data.read_index  = in_ch.read_index;

    unique case (in_ch.operation)
      tcw_pkg::OP_PUT: begin
        if (esc_r) begin
          color_nxt = in_ch.char_byte;
          esc_nxt   = 1'b0;
        end else begin
          case (in_ch.char_byte)
            tcw_pkg::CH_ESC: esc_nxt = 1'b1;
            tcw_pkg::CH_NUL: esc_nxt = esc_r;  // ignored
            tcw_pkg::CH_NL: begin
              col_nxt  = '0;
              row_wide = row_wide + 1'b1;
            end
            tcw_pkg::CH_BS: begin
              wr_char = tcw_pkg::CH_BLANK;
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
                wr_en   = 1'b1;
                wr_col  = col_r - 1'b1;
              end else if (row_r != '0) begin
                col_nxt  = COL_LAST;
                row_wide = row_wide - 1'b1;
                wr_en    = 1'b1;
                wr_col   = COL_LAST;
                wr_row   = row_r - 1'b1;
              end else begin
                // at home: move to the last column, blank nothing
                col_nxt = COL_LAST;
              end
            end
            default: begin
              wr_en = 1'b1;
              if (col_inc == COL_END) begin
                col_nxt  = '0;
                row_wide = row_wide + 1'b1;
              end else begin
                col_nxt = col_inc[CW-1:0];
              end
            end
          endcase
          if (row_wide == ROW_END) begin
            scroll   = 1'b1;
            row_wide = ROW_LAST;
          end
        end
      end
      tcw_pkg::OP_READ: cmd_data.kind = tcw_pkg::CMD_READ;
      tcw_pkg::OP_CLEAR: begin
        cmd_data.kind = tcw_pkg::CMD_CLEAR;
        col_nxt       = '0;
        row_wide      = '0;
      end
      default: cmd_data.kind = tcw_pkg::CMD_NONE;
    endcase

    row_nxt = row_wide[RW-1:0];
    if (wr_en) begin
      cmd_data.kind = tcw_pkg::CMD_WRITE;
    end
    cmd_data.wr_cell   = {color_r, wr_char};
    cmd_data.wr_col    = tcw_pkg::COL_MAX_W'(wr_col);
    cmd_data.wr_row    = tcw_pkg::ROW_MAX_W'(wr_row);
    cmd_data.scroll    = scroll;
    cmd_data.rep_col   = tcw_pkg::CURCOL_W'(col_nxt);
    cmd_data.rep_row   = tcw_pkg::CURROW_W'(row_nxt);
    cmd_data.rep_color = color_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      color_r <= tcw_pkg::COLOR_RESET;
      esc_r   <= 1'b0;
    end else if (accept) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      color_r <= color_nxt;
      esc_r   <= esc_nxt;
    end
  end

endmodule

>>> sv/tcw_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on tcw_pkg for the command type and depth.
module tcw_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tcw_pkg::cmd_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tcw_pkg::cmd_t out_data
);

  localparam int unsigned DEPTH = tcw_pkg::CMD_FIFO_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [NW-1:0] CNT_FULL = NW'(DEPTH);

  tcw_pkg::cmd_t  entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]  count_r;
  logic           push, pop;

  assign in_ready  = (count_r != CNT_FULL);
  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> sv/tcw_back.sv
// Back end: carries out commands on the cell memory (row ring, lazy row fill,
// scroll sweep, reads) and holds the result register. Depends on tcw_pkg, tcw_ifs, tcw_ram.
module tcw_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  tcw_pkg::cmd_t cmd_data,
  tcw_out_if.source     out_ch
);

  localparam int unsigned CELLS   = COLUMNS * ROWS;
  localparam int unsigned CW      = $clog2(COLUMNS);
  localparam int unsigned RW      = $clog2(ROWS);
  localparam int unsigned AW      = $clog2(CELLS);
  localparam int unsigned IW      = tcw_pkg::INDEX_W;
  localparam int unsigned SW      = ((AW > IW) ? AW : IW) + 1;
  localparam int unsigned DIV_K   = IW + CW;
  localparam int unsigned RECIP   = ((1 << DIV_K) + COLUMNS - 1) / COLUMNS;
  localparam int unsigned RECIP_W = IW + 2;
  localparam int unsigned PROD_W  = IW + RECIP_W;
  localparam int unsigned QW      = PROD_W - DIV_K;

  localparam logic [RECIP_W-1:0] RECIP_V   = RECIP_W'(RECIP);
  localparam logic [CW-1:0]      COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]      ROW_LAST  = RW'(ROWS - 1);
  localparam logic [RW:0]        ROWS_V    = (RW + 1)'(ROWS);
  localparam logic [AW-1:0]      OFF_LAST  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0]      COLS_A    = AW'(COLUMNS);
  localparam logic [SW-1:0]      CELLS_S   = SW'(CELLS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_ADDR,
    S_FILL,
    S_WRITE,
    S_SCROLL,
    S_RD_MUL,
    S_RD_ADDR,
    S_RD_MEM,
    S_RD_DATA,
    S_DONE
  } state_t;

  state_t                          state_r;
  tcw_pkg::cmd_t                   cmd_r;
  logic [ROWS-1:0]                 row_valid_r;
  logic [tcw_pkg::COLOR_W-1:0]     clear_color_r;
  logic [RW-1:0]                   base_r;
  logic [AW-1:0]                   base_off_r;
  logic [RW-1:0]                   prow_r;
  logic [AW-1:0]                   row_addr_r;
  logic [CW-1:0]                   col_cnt_r;
  logic [PROD_W-1:0]               prod_r;
  logic [AW-1:0]                   rd_addr_r;
  logic                            in_range_r;
  logic [tcw_pkg::CELL_W-1:0]      cell_r;

  logic                            out_valid_r;
  logic [tcw_pkg::CELL_W-1:0]      out_cell_r;
  logic [tcw_pkg::CURCOL_W-1:0]    out_col_r;
  logic [tcw_pkg::CURROW_W-1:0]    out_row_r;
  logic [tcw_pkg::COLOR_W-1:0]     out_color_r;
  logic                            out_scroll_r;

  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]      mem_wdata;
  logic [tcw_pkg::CELL_W-1:0]      mem_rdata;

  logic [RW:0]                     wr_row_sum;
  logic [RW-1:0]                   wr_prow;
  logic [QW-1:0]                   rd_row_l;
  logic [RW:0]                     rd_row_sum;
  logic [RW-1:0]                   rd_prow;
  logic [SW-1:0]                   rd_sum;
  logic [AW-1:0]                   rd_paddr;
  logic [tcw_pkg::CELL_W-1:0]      blank_clear;

  assign cmd_ready   = (state_r == S_IDLE);
  assign blank_clear = {clear_color_r, tcw_pkg::CH_BLANK};

  // Logical row to physical row through the ring base
  assign wr_row_sum = {1'b0, cmd_r.wr_row[RW-1:0]} + {1'b0, base_r};
  assign wr_prow    = (wr_row_sum >= ROWS_V) ? RW'(wr_row_sum - ROWS_V) : wr_row_sum[RW-1:0];

  // Read index: row by reciprocal multiply, address by ring offset
  assign rd_row_l   = prod_r[PROD_W-1:DIV_K];
  assign rd_row_sum = (RW + 1)'(rd_row_l) + {1'b0, base_r};
  assign rd_prow    = (rd_row_sum >= ROWS_V) ? RW'(rd_row_sum - ROWS_V) : rd_row_sum[RW-1:0];
  assign rd_sum     = SW'(cmd_r.read_index) + SW'(base_off_r);
  assign rd_paddr   = (rd_sum >= CELLS_S) ? AW'(rd_sum - CELLS_S) : rd_sum[AW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(row_addr_r + AW'(col_cnt_r));
    mem_wdata = blank_clear;
    unique case (state_r)
      S_FILL: mem_we = 1'b1;
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(row_addr_r + AW'(cmd_r.wr_col[CW-1:0]));
        mem_wdata = cmd_r.wr_cell;
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = {cmd_r.blank_color, tcw_pkg::CH_BLANK};
      end
      default: mem_we = 1'b0;
    endcase
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr_r),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      row_valid_r   <= '0;
      clear_color_r <= tcw_pkg::COLOR_RESET;
      base_r        <= '0;
      base_off_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // S_DONE reloads the result register on its own
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r  <= cmd_data;
            cell_r <= '0;
            unique case (cmd_data.kind)
              tcw_pkg::CMD_WRITE: state_r <= S_PREP;
              tcw_pkg::CMD_READ:  state_r <= S_RD_MUL;
              tcw_pkg::CMD_CLEAR: begin
                // drop every row back to blank in the current colour
                row_valid_r   <= '0;
                clear_color_r <= cmd_data.blank_color;
                state_r       <= S_DONE;
              end
              default: begin
                if (cmd_data.scroll) begin
                  row_addr_r <= base_off_r;
                  prow_r     <= base_r;
                  col_cnt_r  <= '0;
                  state_r    <= S_SCROLL;
                end else begin
                  state_r <= S_DONE;
                end
              end
            endcase
          end
        end
        S_PREP: begin
          prow_r  <= wr_prow;
          state_r <= S_ADDR;
        end
        S_ADDR: begin
          row_addr_r <= AW'(prow_r * COLUMNS);
          col_cnt_r  <= '0;
          state_r    <= row_valid_r[prow_r] ? S_WRITE : S_FILL;
        end
        S_FILL: begin
          if (col_cnt_r == COL_LAST) begin
            row_valid_r[prow_r] <= 1'b1;
            state_r             <= S_WRITE;
          end else begin
            col_cnt_r <= col_cnt_r + 1'b1;
          end
        end
        S_WRITE: begin
          if (cmd_r.scroll) begin
            row_addr_r <= base_off_r;
            prow_r     <= base_r;
            col_cnt_r  <= '0;
            state_r    <= S_SCROLL;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SCROLL: begin
          if (col_cnt_r == COL_LAST) begin
            row_valid_r[prow_r] <= 1'b1;
            base_r              <= (base_r == ROW_LAST) ? '0 : base_r + 1'b1;
            base_off_r          <= (base_off_r == OFF_LAST) ? '0 : base_off_r + COLS_A;
            state_r             <= S_DONE;
          end else begin
            col_cnt_r <= col_cnt_r + 1'b1;
          end
        end
        S_RD_MUL: begin
          prod_r  <= {{RECIP_W{1'b0}}, cmd_r.read_index} * {{IW{1'b0}}, RECIP_V};
          state_r <= S_RD_ADDR;
        end
        S_RD_ADDR: begin
          in_range_r <= (32'(cmd_r.read_index) < CELLS);
          prow_r     <= rd_prow;
          rd_addr_r  <= rd_paddr;
          state_r    <= S_RD_MEM;
        end
        S_RD_MEM: state_r <= S_RD_DATA;
        S_RD_DATA: begin
          if (!in_range_r) begin
            cell_r <= '0;
          end else if (row_valid_r[prow_r]) begin
            cell_r <= mem_rdata;
          end else begin
            cell_r <= blank_clear;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_cell_r   <= cell_r;
            out_col_r    <= cmd_r.rep_col;
            out_row_r    <= cmd_r.rep_row;
            out_color_r  <= cmd_r.rep_color;
            out_scroll_r <= cmd_r.scroll;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cell_data     = out_cell_r;
  assign out_ch.cursor_column = out_col_r;
  assign out_ch.cursor_row    = out_row_r;
  assign out_ch.text_color    = out_color_r;
  assign out_ch.scrolled      = out_scroll_r;

`ifndef SYNTHESIS
  a_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(base_r) < ROWS)
    else $error("ring base past last row");

  a_base_offset: assert property (@(posedge clk) disable iff (!rst_n)
    base_off_r == AW'(base_r * COLUMNS))
    else $error("ring cell offset out of step with ring base");

  a_clear_drops_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cmd_valid && cmd_data.kind == tcw_pkg::CMD_CLEAR)
      |=> (row_valid_r == '0))
    else $error("clear left a row marked filled");

  a_write_filled_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> row_valid_r[prow_r])
    else $error("cell write into a row that was never filled");
`endif

endmodule

>>> sv/text_console_writer.sv
// Top level of the text console writer: front end, command queue, back end.
// Depends on tcw_pkg, tcw_ifs, tcw_front, tcw_cmd_fifo, tcw_back.
//
// Usage:
//   in_ch carries one word per item: operation (put byte, read cell, clear),
//   char_byte for put and read_index (row * COLUMNS + column) for read.
//   out_ch returns exactly one word per item, in order: the cell read (0 for
//   other operations or an index past the grid), cursor column and row after
//   the item, the current colour, and a flag that the item scrolled the grid.
// Back end steps (one item at a time):
//   put that writes a cell    row lookup, address, cell write; a row is
//                             filled on its first touch after reset or clear
//   put that scrolls          add a sweep that blanks the new bottom row
//   read                      multiply, address, RAM read
//   clear, escape, NUL        no cell memory access
//   The row sweeps go through the single cell RAM write port.
// Reset holds no clearing pass: all rows read as blank 0x0F20 until written.
// A stalled out_ch holds its word; the front end keeps taking input words
// until the command queue fills.
module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  tcw_in_if.sink     in_ch,
  tcw_out_if.source  out_ch
);

  // front end to queue
  logic          fq_valid;
  logic          fq_ready;
  tcw_pkg::cmd_t fq_data;

  // queue to back end
  logic          qb_valid;
  logic          qb_ready;
  tcw_pkg::cmd_t qb_data;

  // Classify words and advance the cursor
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  // Decouple front from the multi-cycle back end
  tcw_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  // Carry out memory work and hold the result word
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd_data  (qb_data),
    .out_ch    (out_ch)
  );

endmodule
